/* hdl/stree_pkg.sv */
package stree_pkg;

  localparam int DATA_W    = 32;
  localparam int POS_W     = 8;
  localparam int CNT_W     = 9;
  localparam int NODE_W    = 10;
  localparam int STK_DEPTH = 16;
  localparam int STK_AW    = $clog2(STK_DEPTH);
  localparam int SP_W      = STK_AW + 1;

  localparam logic [CNT_W-1:0] CNT_RESET = 9'd256;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_W_LEAF,
    ST_W_RD,
    ST_W_ADD,
    ST_Q_VISIT,
    ST_Q_ACC,
    ST_DONE
  } st_state_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [POS_W-1:0]  s;
    logic [POS_W-1:0]  e;
  } st_span_t;

  typedef struct packed {
    logic              leaf_we;
    logic [POS_W-1:0]  leaf_idx;
    logic [DATA_W-1:0] leaf_wdata;
    logic              node_we;
    logic [NODE_W-1:0] node_idx;
    logic [DATA_W-1:0] node_wdata;
  } st_mem_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              sub;
  } st_alu_req_t;

endpackage

/* hdl/segment_tree_range_sum.sv */
// Segment tree of signed 32-bit values with point writes and inclusive range-sum
// queries. An item is taken when start is high and busy is low. A write item walks
// the tree from the root down to its leaf and gives no result; a write at or beyond
// count_in_use (a count of 0 counts as 1) is dropped at once. A query visits tree
// nodes and adds each one that lies wholly inside the range, and its sum appears on
// out_range_sum for exactly one cycle with out_valid; the receiver cannot stall it.
// The node store has a single port. After reset and after every write of
// count_in_use, both stores are zeroed by a sweep over max(MAX_POSITIONS,
// TREE_NODES) addresses with busy held high.
module segment_tree_range_sum #(
  parameter int MAX_POSITIONS = 256,
  parameter int TREE_NODES    = 511
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_kind,
  input  logic [stree_pkg::POS_W-1:0]         in_position,
  input  logic signed [stree_pkg::DATA_W-1:0] in_value,
  input  logic [stree_pkg::POS_W-1:0]         in_query_lo,
  input  logic [stree_pkg::POS_W-1:0]         in_query_hi,
  output logic                                out_valid,
  output logic signed [stree_pkg::DATA_W-1:0] out_range_sum,
  input  logic                                cfg_we,
  input  logic [stree_pkg::CNT_W-1:0]         cfg_wdata
);
  import stree_pkg::*;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  n_active;
  logic              clearing;
  logic              ctrl_idle;
  logic              go;
  st_mem_req_t       mem_req;
  st_alu_req_t       alu_req;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] leaf_rd;
  logic [DATA_W-1:0] node_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_RESET;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (count_r == '0) begin
      n_active = CNT_W'(1);
    end else if (32'(count_r) > MAX_POSITIONS) begin
      n_active = CNT_W'(MAX_POSITIONS);
    end else begin
      n_active = count_r;
    end
  end

  assign busy = !ctrl_idle || clearing || cfg_we;
  assign go   = start && !busy;

  stree_ctrl #(
    .TREE_NODES(TREE_NODES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (go),
    .in_kind      (in_kind),
    .in_position  (in_position),
    .in_value     (in_value),
    .in_query_lo  (in_query_lo),
    .in_query_hi  (in_query_hi),
    .n_active     (n_active),
    .leaf_rd      (leaf_rd),
    .node_rd      (node_rd),
    .alu_res      (alu_res),
    .mem_req      (mem_req),
    .alu_req      (alu_req),
    .idle         (ctrl_idle),
    .out_valid    (out_valid),
    .out_range_sum(out_range_sum)
  );

  stree_alu u_alu (
    .req(alu_req),
    .res(alu_res)
  );

  stree_store #(
    .MAX_POSITIONS(MAX_POSITIONS),
    .TREE_NODES   (TREE_NODES)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_start(cfg_we),
    .req      (mem_req),
    .clearing (clearing),
    .leaf_rd  (leaf_rd),
    .node_rd  (node_rd)
  );

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (go && in_kind == KIND_WRITE) |=> !out_valid)
    else $error("result strobe right after a write item");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("count write did not start the store clear");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("item accepted while a result is on the output");

endmodule

/* hdl/stree_alu.sv */
module stree_alu (
  input  stree_pkg::st_alu_req_t        req,
  output logic [stree_pkg::DATA_W-1:0]  res
);
  import stree_pkg::*;

  assign res = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

/* hdl/stree_store.sv */
module stree_store #(
  parameter int MAX_POSITIONS = 256,
  parameter int TREE_NODES    = 511
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clr_start,
  input  stree_pkg::st_mem_req_t        req,
  output logic                          clearing,
  output logic [stree_pkg::DATA_W-1:0]  leaf_rd,
  output logic [stree_pkg::DATA_W-1:0]  node_rd
);
  import stree_pkg::*;

  localparam int LEAF_AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int NODE_AW = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1;
  localparam int CLR_LEN = (MAX_POSITIONS > TREE_NODES) ? MAX_POSITIONS : TREE_NODES;
  localparam int CLR_W   = $clog2(CLR_LEN);

  logic [DATA_W-1:0] leaf_mem [MAX_POSITIONS];
  logic [DATA_W-1:0] node_mem [TREE_NODES];

  logic              clr_r;
  logic [CLR_W-1:0]  clr_cnt_r;
  logic [DATA_W-1:0] leaf_rd_r;
  logic [DATA_W-1:0] node_rd_r;

  // zero sweep over both stores, one address per cycle
  always_ff @(posedge clk) begin
    if (!rst_n || clr_start) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      if (clr_cnt_r == CLR_W'(CLR_LEN - 1)) begin
        clr_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + CLR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      if (32'(clr_cnt_r) < MAX_POSITIONS) begin
        leaf_mem[LEAF_AW'(clr_cnt_r)] <= '0;
      end
    end else if (req.leaf_we) begin
      leaf_mem[LEAF_AW'(req.leaf_idx)] <= req.leaf_wdata;
    end
    leaf_rd_r <= leaf_mem[LEAF_AW'(req.leaf_idx)];
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      if (32'(clr_cnt_r) < TREE_NODES) begin
        node_mem[NODE_AW'(clr_cnt_r)] <= '0;
      end
    end else if (req.node_we) begin
      node_mem[NODE_AW'(req.node_idx)] <= req.node_wdata;
    end
    node_rd_r <= node_mem[NODE_AW'(req.node_idx)];
  end

  assign clearing = clr_r;
  assign leaf_rd  = leaf_rd_r;
  assign node_rd  = node_rd_r;

endmodule

/* hdl/stree_ctrl.sv */
module stree_ctrl #(
  parameter int TREE_NODES = 511
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  logic                                in_kind,
  input  logic [stree_pkg::POS_W-1:0]         in_position,
  input  logic signed [stree_pkg::DATA_W-1:0] in_value,
  input  logic [stree_pkg::POS_W-1:0]         in_query_lo,
  input  logic [stree_pkg::POS_W-1:0]         in_query_hi,
  input  logic [stree_pkg::CNT_W-1:0]         n_active,
  input  logic [stree_pkg::DATA_W-1:0]        leaf_rd,
  input  logic [stree_pkg::DATA_W-1:0]        node_rd,
  input  logic [stree_pkg::DATA_W-1:0]        alu_res,
  output stree_pkg::st_mem_req_t              mem_req,
  output stree_pkg::st_alu_req_t              alu_req,
  output logic                                idle,
  output logic                                out_valid,
  output logic signed [stree_pkg::DATA_W-1:0] out_range_sum
);
  import stree_pkg::*;

  st_state_t         state_r, state_nxt;
  st_span_t          cur_r, cur_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  lo_r, lo_nxt;
  logic [POS_W-1:0]  hi_r, hi_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W-1:0] delta_r, delta_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  st_span_t          stk_r [STK_DEPTH];

  logic [CNT_W-1:0]  nm1;
  logic [POS_W-1:0]  hi_clip;
  logic [POS_W:0]    mid_sum;
  logic [POS_W-1:0]  mid;
  logic [NODE_W-1:0] lchild;
  logic [NODE_W-1:0] rchild;
  logic [SP_W-1:0]   sp_dec;
  logic              node_ok;
  logic              push;
  logic              pop;
  st_span_t          root;

  assign nm1     = n_active - CNT_W'(1);
  assign hi_clip = ({1'b0, in_query_hi} > nm1) ? POS_W'(nm1) : in_query_hi;
  assign mid_sum = {1'b0, cur_r.s} + {1'b0, cur_r.e};
  assign mid     = mid_sum[POS_W:1];
  assign lchild  = {cur_r.node[NODE_W-2:0], 1'b1};
  assign rchild  = lchild + NODE_W'(1);
  assign sp_dec  = sp_r - SP_W'(1);
  assign node_ok = 32'(cur_r.node) < TREE_NODES;
  assign root    = '{node: '0, s: '0, e: POS_W'(nm1)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    pos_r   <= pos_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    val_r   <= val_nxt;
    delta_r <= delta_nxt;
    acc_r   <= acc_nxt;
    if (push) begin
      stk_r[sp_r[STK_AW-1:0]] <= '{node: rchild, s: mid + POS_W'(1), e: cur_r.e};
    end
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    pos_nxt   = pos_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    val_nxt   = val_r;
    delta_nxt = delta_r;
    acc_nxt   = acc_r;
    sp_nxt    = sp_r;
    push      = 1'b0;
    pop       = 1'b0;
    mem_req   = '0;
    alu_req   = '0;
    out_valid = 1'b0;

    case (state_r)
      ST_IDLE: begin
        mem_req.leaf_idx = in_position;
        if (go) begin
          if (in_kind == KIND_WRITE) begin
            if ({1'b0, in_position} < n_active) begin
              pos_nxt   = in_position;
              val_nxt   = in_value;
              state_nxt = ST_W_LEAF;
            end
          end else begin
            lo_nxt    = in_query_lo;
            hi_nxt    = hi_clip;
            acc_nxt   = '0;
            sp_nxt    = '0;
            cur_nxt   = root;
            state_nxt = (in_query_lo > hi_clip) ? ST_DONE : ST_Q_VISIT;
          end
        end
      end

      ST_W_LEAF: begin
        alu_req            = '{a: val_r, b: leaf_rd, sub: 1'b1};
        delta_nxt          = alu_res;
        mem_req.leaf_we    = 1'b1;
        mem_req.leaf_idx   = pos_r;
        mem_req.leaf_wdata = val_r;
        cur_nxt            = root;
        state_nxt          = ST_W_RD;
      end

      ST_W_RD: begin
        mem_req.node_idx = cur_r.node;
        state_nxt        = node_ok ? ST_W_ADD : ST_IDLE;
      end

      ST_W_ADD: begin
        alu_req            = '{a: node_rd, b: delta_r, sub: 1'b0};
        mem_req.node_we    = 1'b1;
        mem_req.node_idx   = cur_r.node;
        mem_req.node_wdata = alu_res;
        if (cur_r.s == cur_r.e) begin
          state_nxt = ST_IDLE;
        end else begin
          if (pos_r <= mid) begin
            cur_nxt = '{node: lchild, s: cur_r.s, e: mid};
          end else begin
            cur_nxt = '{node: rchild, s: mid + POS_W'(1), e: cur_r.e};
          end
          state_nxt = ST_W_RD;
        end
      end

      ST_Q_VISIT: begin
        if (cur_r.e < lo_r || cur_r.s > hi_r || !node_ok) begin
          pop = 1'b1;
        end else if (lo_r <= cur_r.s && hi_r >= cur_r.e) begin
          mem_req.node_idx = cur_r.node;
          state_nxt        = ST_Q_ACC;
        end else begin
          push    = 1'b1;
          sp_nxt  = sp_r + SP_W'(1);
          cur_nxt = '{node: lchild, s: cur_r.s, e: mid};
        end
      end

      ST_Q_ACC: begin
        alu_req = '{a: acc_r, b: node_rd, sub: 1'b0};
        acc_nxt = alu_res;
        pop     = 1'b1;
      end

      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (pop) begin
      if (sp_r == '0) begin
        state_nxt = ST_DONE;
      end else begin
        cur_nxt   = stk_r[sp_dec[STK_AW-1:0]];
        sp_nxt    = sp_dec;
        state_nxt = ST_Q_VISIT;
      end
    end
  end

  assign idle          = (state_r == ST_IDLE);
  assign out_range_sum = acc_r;

endmodule

/* tb/tb_segment_tree_range_sum.sv */
`timescale 1ns / 1ps

module tb_segment_tree_range_sum;
  import stree_pkg::*;

  localparam int N_MAX       = 256;
  localparam int DRAIN_WAIT  = 80;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_ITEMS  = 950;
  localparam int N_PHASES    = 10;
  localparam int PRINT_CAP   = 200;

  typedef enum logic {
    ROW_ITEM,
    ROW_COUNT
  } row_op_t;

  typedef struct {
    row_op_t           op;
    logic              kind;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
    bit                fixed;
    logic [DATA_W-1:0] sum;
  } dir_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_kind;
  logic [POS_W-1:0]         in_position;
  logic signed [DATA_W-1:0] in_value;
  logic [POS_W-1:0]         in_query_lo;
  logic [POS_W-1:0]         in_query_hi;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_range_sum;
  logic                     cfg_we;
  logic [CNT_W-1:0]         cfg_wdata;

  segment_tree_range_sum i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_position   (in_position),
    .in_value      (in_value),
    .in_query_lo   (in_query_lo),
    .in_query_hi   (in_query_hi),
    .out_valid     (out_valid),
    .out_range_sum (out_range_sum),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  // shadow of the array contents and the count register
  logic [CNT_W-1:0]  shadow_count;
  logic [DATA_W-1:0] shadow_leaf [N_MAX];

  logic [DATA_W-1:0] sums_due [$];
  dir_row_t          dir_rows [$];

  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned gap_due;
  int unsigned burst_left;
  bit          no_idle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned positions_live();
    if (shadow_count == '0) return 1;
    if (32'(shadow_count) > N_MAX) return N_MAX;
    return 32'(shadow_count);
  endfunction

  function automatic void clear_shadow();
    foreach (shadow_leaf[p]) shadow_leaf[p] = '0;
  endfunction

  function automatic logic [DATA_W-1:0] span_total(int unsigned lo, int unsigned hi);
    logic [DATA_W-1:0] acc;
    int unsigned       n;
    acc = '0;
    n   = positions_live();
    if (hi > n - 1) hi = n - 1;
    if (lo > hi) return '0;
    for (int unsigned p = lo; p <= hi; p++) acc += shadow_leaf[p];
    return acc;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned next_gap();
    if (no_idle) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 15);
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 70);
    return $urandom_range(1, 6);
  endfunction

  function automatic dir_row_t wr_row(logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
    dir_row_t r;
    r = '{ROW_ITEM, KIND_WRITE, pos, val, 8'hFF, 8'h00, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t q_row(logic [POS_W-1:0] lo, logic [POS_W-1:0] hi,
                                     bit fixed, logic [DATA_W-1:0] sum);
    dir_row_t r;
    r = '{ROW_ITEM, KIND_QUERY, POS_W'($urandom), DATA_W'($urandom), lo, hi, fixed, sum};
    return r;
  endfunction

  function automatic dir_row_t cnt_row(logic [CNT_W-1:0] cnt);
    dir_row_t r;
    r = '{ROW_COUNT, KIND_WRITE, '0, DATA_W'(cnt), '0, '0, 1'b0, '0};
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (err_count < PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // drives one item and waits until it is taken
  task automatic send_item(logic kind, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val,
                           logic [POS_W-1:0] lo, logic [POS_W-1:0] hi,
                           bit fixed, logic [DATA_W-1:0] fixed_sum);
    logic [DATA_W-1:0] s;
    if (gap_due > 0) repeat (gap_due) @(posedge clk);
    start       <= 1'b1;
    in_kind     <= kind;
    in_position <= pos;
    in_value    <= val;
    in_query_lo <= lo;
    in_query_hi <= hi;
    do @(posedge clk); while (busy);
    if (kind == KIND_WRITE) begin
      if (32'(pos) < positions_live()) shadow_leaf[pos] = val;
    end else begin
      s = span_total(32'(lo), 32'(hi));
      sums_due.push_back(fixed ? fixed_sum : s);
    end
    gap_due = next_gap();
    if (gap_due != 0) start <= 1'b0;
  endtask

  task automatic quiesce();
    if (gap_due == 0) begin
      start   <= 1'b0;
      gap_due = 1;
    end
    while (sums_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_count(logic [CNT_W-1:0] cnt);
    quiesce();
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_we       <= 1'b0;
    shadow_count = cnt;
    clear_shadow();
    repeat (4) @(posedge clk);
  endtask

  task automatic random_item();
    int unsigned       n;
    logic              kind;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
    logic [POS_W-1:0]  tmp;
    n    = positions_live();
    kind = ($urandom_range(0, 1) == 0) ? KIND_WRITE : KIND_QUERY;
    if (kind == KIND_WRITE) begin
      pos = POS_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, n - 1));
      send_item(kind, pos, pick_value(), POS_W'($urandom), POS_W'($urandom), 1'b0, '0);
    end else begin
      lo = POS_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, n - 1));
      hi = POS_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, n - 1));
      if (lo > hi && $urandom_range(0, 3) != 0) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      send_item(kind, POS_W'($urandom), DATA_W'($urandom), lo, hi, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    logic [DATA_W-1:0] want;
    if (rst_n && out_valid) begin
      if (sums_due.size() == 0) begin
        report_mismatch($sformatf("result %08h with no query pending", out_range_sum));
      end else begin
        want = sums_due.pop_front();
        if (out_range_sum !== want)
          report_mismatch($sformatf("range_sum got %08h want %08h", out_range_sum, want));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_segment_tree_range_sum failed");
      $finish;
    end
  end

  initial begin
    logic [CNT_W-1:0] phase_counts [N_PHASES];
    dir_row_t         r;
    err_count    = 0;
    cycle_count  = 0;
    gap_due      = 0;
    burst_left   = 0;
    no_idle      = 1'b0;
    shadow_count = CNT_RESET;
    clear_shadow();
    rst_n       = 1'b0;
    start       = 1'b0;
    in_kind     = KIND_WRITE;
    in_position = '0;
    in_value    = '0;
    in_query_lo = '0;
    in_query_hi = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;

    // directed: extremes, wrap, clipping, empty range, ignored writes, count limits
    dir_rows.push_back(q_row(8'd0, 8'd255, 1'b1, 32'h0000_0000));
    dir_rows.push_back(wr_row(8'd0, 32'h7FFF_FFFF));
    dir_rows.push_back(wr_row(8'd255, 32'h8000_0000));
    dir_rows.push_back(q_row(8'd0, 8'd255, 1'b1, 32'hFFFF_FFFF));
    dir_rows.push_back(q_row(8'd0, 8'd0, 1'b1, 32'h7FFF_FFFF));
    dir_rows.push_back(q_row(8'd255, 8'd255, 1'b1, 32'h8000_0000));
    dir_rows.push_back(q_row(8'd200, 8'd100, 1'b1, 32'h0000_0000));
    dir_rows.push_back(wr_row(8'd1, 32'h7FFF_FFFF));
    dir_rows.push_back(q_row(8'd0, 8'd1, 1'b1, 32'hFFFF_FFFE));
    dir_rows.push_back(wr_row(8'd0, 32'h0000_0000));
    dir_rows.push_back(q_row(8'd0, 8'd254, 1'b0, '0));
    dir_rows.push_back(cnt_row(9'd5));
    dir_rows.push_back(q_row(8'd0, 8'd255, 1'b1, 32'h0000_0000));
    dir_rows.push_back(wr_row(8'd4, 32'hFFFF_FFFF));
    dir_rows.push_back(wr_row(8'd5, 32'd123));
    dir_rows.push_back(wr_row(8'd255, 32'd7));
    dir_rows.push_back(q_row(8'd0, 8'd255, 1'b1, 32'hFFFF_FFFF));
    dir_rows.push_back(q_row(8'd5, 8'd255, 1'b1, 32'h0000_0000));
    dir_rows.push_back(q_row(8'd4, 8'd4, 1'b1, 32'hFFFF_FFFF));
    dir_rows.push_back(cnt_row(9'd0));
    dir_rows.push_back(wr_row(8'd0, 32'h1234_5678));
    dir_rows.push_back(wr_row(8'd1, 32'd5));
    dir_rows.push_back(q_row(8'd0, 8'd255, 1'b1, 32'h1234_5678));
    dir_rows.push_back(cnt_row(9'h1FF));
    dir_rows.push_back(wr_row(8'd255, 32'hFFFF_FFFB));
    dir_rows.push_back(q_row(8'd250, 8'd255, 1'b1, 32'hFFFF_FFFB));

    phase_counts = '{9'd256, 9'd1, 9'd2, 9'd3, 9'd7, 9'd64, 9'd129, 9'd255,
                     9'd256, 9'd0};
    phase_counts[N_PHASES-1] = CNT_W'($urandom_range(1, 256));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      r = dir_rows[k];
      if (r.op == ROW_COUNT) set_count(r.val[CNT_W-1:0]);
      else send_item(r.kind, r.pos, r.val, r.lo, r.hi, r.fixed, r.sum);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_count(phase_counts[ph]);
      no_idle    = (ph == 3) || (ph == N_PHASES - 1);
      burst_left = 0;
      for (int i = 0; i < RAND_ITEMS / N_PHASES; i++) random_item();
    end

    quiesce();
    if (err_count == 0) begin
      $display("tb_segment_tree_range_sum passed");
    end else begin
      $display("tb_segment_tree_range_sum failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/stree_pkg.sv
hdl/stree_alu.sv
hdl/stree_store.sv
hdl/stree_ctrl.sv
hdl/segment_tree_range_sum.sv
tb/tb_segment_tree_range_sum.sv
